// ----- src/abp_pkg.sv -----
// Shared types and constants for the affinity bank placement block.
// No dependencies; imported by abp_engine and affinity_bank_placement_core.
`timescale 1ns / 1ps
package abp_pkg;

   localparam int ADDR_W    = 48;
   localparam int BANK_W    = 4;
   localparam int MAX_BANKS = 16;
   localparam int NB_W      = 5;
   localparam int FACTOR_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BANK_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_FACTOR = 1'b1;

   localparam logic [NB_W-1:0]     BANK_COUNT_RESET   = 5'd16;
   localparam logic [FACTOR_W-1:0] BATCH_FACTOR_RESET = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_SRCH, S_CMP, S_SEQ, S_CLR,
      S_PRD0, S_PRD1, S_PRD2, S_PINC1, S_PRD3, S_PINC2,
      S_WRD, S_WACC, S_LBA, S_LGET, S_LRD, S_LCMP,
      S_SRD, S_SCMP, S_PICK, S_BRD, S_BACC, S_BEST, S_BADDR, S_EMIT, S_FIN
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [BANK_W-1:0] bank;
      logic              full;
      logic              last;
   } result_type;

endpackage

// ----- src/affinity_bank_placement_core.sv -----
// Top level of the affinity bank placement block: stream ports, register file,
// output register. Depends on abp_pkg and abp_engine.
`timescale 1ns / 1ps
// Collects access addresses into batches of min(batch_factor * bank_count,
// MAX_BATCH) and, at batch end or on an end-of-trace transaction (tuser = 1),
// places every not-yet-placed distinct address on the bank with the least
// co-access affinity to this batch's already placed addresses, one result
// transaction per placement, tlast on the batch's final one. Each access is
// compared in turn with the distinct addresses stored so far in the batch
// address memory. Evaluating a batch runs a matrix clear, a read-modify-write
// of the affinity memory for each pair of consecutive accesses, row sums, a
// placed-store search for each vertex and the placement rounds. No transaction
// is taken on the request side while a batch is evaluated. No clearing pass is
// needed after reset. Configuration writes are taken in any cycle and must only
// be issued while the block is idle.
module affinity_bank_placement_core import abp_pkg::*; #(
   parameter int MAX_BATCH       = 64,
   parameter int PLACED_CAPACITY = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ADDR_W-1:0]    req_tdata,   // [47:0] address
   input  logic                 req_tuser,   // [0] op: 1 = end of trace
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,   // [47:0] placed_address, [51:48] bank_index,
                                             // [52] store_full, [55:53] zero
   output logic                 rsp_tlast,   // last
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [NB_W-1:0]      csr_data
);

   localparam int CW = $clog2(MAX_BATCH+1);

   logic [NB_W-1:0]     bank_count_ff, bank_count_in;
   logic [FACTOR_W-1:0] batch_factor_ff, batch_factor_in;
   logic [NB_W-1:0]     nb_eff;
   logic [FACTOR_W-1:0] f_eff;
   logic [7:0]          prod;
   logic [CW-1:0]       limit;

   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;
   logic                eng_valid, eng_ready;
   result_type          eng_data;

   // register file: always ready, write by index
   assign csr_ready = 1'b1;

   always_comb begin
      bank_count_in   = bank_count_ff;
      batch_factor_in = batch_factor_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BANK_COUNT:   bank_count_in   = csr_data;
            CSR_BATCH_FACTOR: batch_factor_in = csr_data[FACTOR_W-1:0];
            default:          bank_count_in   = bank_count_ff;
         endcase
      end
   end

   // clamp bank count to 1..MAX_BANKS, factor zero acts as one
   always_comb begin
      if (bank_count_ff == '0)                      nb_eff = NB_W'(1);
      else if (bank_count_ff > NB_W'(MAX_BANKS))    nb_eff = NB_W'(MAX_BANKS);
      else                                          nb_eff = bank_count_ff;
      f_eff = (batch_factor_ff == '0) ? FACTOR_W'(1) : batch_factor_ff;
      prod  = 8'(f_eff) * 8'(nb_eff);
      limit = (prod > 8'(MAX_BATCH)) ? CW'(MAX_BATCH) : CW'(prod);
   end

   abp_engine #(
      .MAX_BATCH       (MAX_BATCH),
      .PLACED_CAPACITY (PLACED_CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_flush  (req_tuser),
      .in_addr   (req_tdata),
      .nb        (nb_eff),
      .limit     (limit),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_data  (eng_data)
   );

   // output register: refill while the held transaction drains
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff   <= BANK_COUNT_RESET;
         batch_factor_ff <= BATCH_FACTOR_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bank_count_ff   <= bank_count_in;
         batch_factor_ff <= batch_factor_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.full, rsp_ff.bank, rsp_ff.addr};
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ----- src/abp_engine.sv -----
// Batch collection, affinity graph build and bank placement sequencer.
// Holds all batch and placement memories; depends on abp_pkg.
`timescale 1ns / 1ps
module abp_engine import abp_pkg::*; #(
   parameter int MAX_BATCH       = 64,
   parameter int PLACED_CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_flush,
   input  logic [ADDR_W-1:0]                  in_addr,
   input  logic [NB_W-1:0]                    nb,
   input  logic [$clog2(MAX_BATCH+1)-1:0]     limit,
   output logic                               out_valid,
   input  logic                               out_ready,
   output result_type                         out_data
);

   localparam int VW = $clog2(MAX_BATCH);
   localparam int CW = $clog2(MAX_BATCH+1);
   localparam int AW = $clog2(2*MAX_BATCH);
   localparam int PW = $clog2(PLACED_CAPACITY);
   localparam int TW = $clog2(PLACED_CAPACITY+1);
   localparam int MD = 1 << (2*VW);

   // memories
   logic [ADDR_W-1:0] ba_mem [MAX_BATCH];
   logic [VW-1:0]     sq_mem [MAX_BATCH];
   logic [AW-1:0]     mt_mem [MD];
   logic [AW-1:0]     vw_mem [MAX_BATCH];
   logic [BANK_W-1:0] vb_mem [MAX_BATCH];
   logic [ADDR_W-1:0] sa_mem [PLACED_CAPACITY];
   logic [BANK_W-1:0] sb_mem [PLACED_CAPACITY];

   logic              ba_re, ba_we, sq_re, sq_we, mt_re, mt_we;
   logic              vw_re, vw_we, vb_re, vb_we, st_re, st_we;
   logic [VW-1:0]     ba_ra, ba_wa, sq_ra, sq_wa, sq_wd, vw_ra, vw_wa, vb_ra, vb_wa;
   logic [VW-1:0]     sq_rd_ff;
   logic [2*VW-1:0]   mt_ra, mt_wa;
   logic [PW-1:0]     st_ra, st_wa;
   logic [ADDR_W-1:0] ba_wd, sa_wd, ba_rd_ff, sa_rd_ff;
   logic [AW-1:0]     mt_wd, vw_wd, mt_rd_ff, vw_rd_ff;
   logic [BANK_W-1:0] vb_wd, sb_wd, vb_rd_ff, sb_rd_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     vc_ff, vc_in, bl_ff, bl_in, v_ff, v_in, i_ff, i_in;
   logic [CW-1:0]     j_ff, j_in, k_ff, k_in, r_ff, r_in;
   logic [VW-1:0]     x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]     acc_ff, acc_in, bestw_ff, bestw_in, bbw_ff, bbw_in;
   logic              have_ff, have_in, pend_v_ff, pend_v_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, vaddr_ff, vaddr_in;
   logic [TW-1:0]     p_ff, p_in, total_ff, total_in, bld_ff, bld_in;
   logic [MAX_BATCH-1:0] vplaced_ff, vplaced_in, visited_ff, visited_in;
   logic [AW-1:0]     bw_ff [MAX_BANKS];
   logic [AW-1:0]     bw_in [MAX_BANKS];
   logic [TW-1:0]     load_ff [MAX_BANKS];
   logic [TW-1:0]     load_in [MAX_BANKS];
   logic [BANK_W-1:0] b_ff, b_in, best_ff, best_in;
   result_type        pend_ff, pend_in;

   logic [CW-1:0]     vc_last, bl_inc;
   logic              j_end, i_end, full, emit_go;
   logic [BANK_W-1:0] bw_sel;
   logic [AW-1:0]     bw_cur;
   logic [TW-1:0]     load_cur;

   assign vc_last  = vc_ff - CW'(1);
   assign bl_inc   = bl_ff + CW'(1);
   assign j_end    = (j_ff == vc_last);
   assign i_end    = (i_ff == vc_last);
   assign full     = (total_ff >= TW'(PLACED_CAPACITY));
   assign emit_go  = !pend_v_ff || out_ready;
   assign bw_sel   = (state_ff == S_BACC) ? vb_rd_ff : b_ff;
   assign bw_cur   = bw_ff[bw_sel];
   assign load_cur = load_ff[b_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               if (in_flush) state_in = (vc_ff != '0) ? S_CLR : S_IDLE;
               else          state_in = S_SRCH;
            end
         end
         S_SRCH:  state_in = (v_ff == vc_ff) ? S_SEQ : S_CMP;
         S_CMP:   state_in = (ba_rd_ff == addr_ff) ? S_SEQ : S_SRCH;
         S_SEQ:   state_in = (bl_inc >= limit) ? S_CLR : S_IDLE;
         S_CLR: begin
            if (i_end && j_end) state_in = (bl_ff >= CW'(2)) ? S_PRD0 : S_WRD;
         end
         S_PRD0:  state_in = S_PRD1;
         S_PRD1:  state_in = S_PRD2;
         S_PRD2:  state_in = S_PINC1;
         S_PINC1: state_in = S_PRD3;
         S_PRD3:  state_in = S_PINC2;
         S_PINC2: state_in = ((k_ff + CW'(2)) < bl_ff) ? S_PRD0 : S_WRD;
         S_WRD:   state_in = S_WACC;
         S_WACC:  state_in = j_end ? S_LBA : S_WRD;
         S_LBA:   state_in = S_LGET;
         S_LGET:  state_in = S_LRD;
         S_LRD: begin
            if (p_ff != total_ff) state_in = S_LCMP;
            else                  state_in = i_end ? S_SRD : S_WRD;
         end
         S_LCMP: begin
            if (sa_rd_ff == vaddr_ff) state_in = i_end ? S_SRD : S_WRD;
            else                      state_in = S_LRD;
         end
         S_SRD:   state_in = S_SCMP;
         S_SCMP:  state_in = i_end ? S_PICK : S_SRD;
         S_PICK: begin
            if (vplaced_ff[x_ff]) state_in = (r_ff == vc_last) ? S_FIN : S_SRD;
            else                  state_in = S_BRD;
         end
         S_BRD:   state_in = S_BACC;
         S_BACC:  state_in = j_end ? S_BEST : S_BRD;
         S_BEST:  state_in = ({1'b0, b_ff} == (nb - NB_W'(1))) ? S_BADDR : S_BEST;
         S_BADDR: state_in = S_EMIT;
         S_EMIT: begin
            if (emit_go) state_in = (r_ff == vc_last) ? S_FIN : S_SRD;
         end
         S_FIN:   state_in = emit_go ? S_IDLE : S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      vc_in = vc_ff;  bl_in = bl_ff;  v_in = v_ff;  i_in = i_ff;  j_in = j_ff;
      k_in = k_ff;    r_in = r_ff;    x_in = x_ff;  y_in = y_ff;  acc_in = acc_ff;
      bestw_in = bestw_ff;  bbw_in = bbw_ff;  have_in = have_ff;  pend_v_in = pend_v_ff;
      addr_in = addr_ff;    vaddr_in = vaddr_ff;  p_in = p_ff;  total_in = total_ff;
      bld_in = bld_ff;  vplaced_in = vplaced_ff;  visited_in = visited_ff;
      bw_in = bw_ff;    load_in = load_ff;  b_in = b_ff;  best_in = best_ff;
      pend_in = pend_ff;
      in_ready = 1'b0;  out_valid = 1'b0;  out_data = pend_ff;  out_data.last = 1'b0;
      ba_re = 1'b0; ba_we = 1'b0; ba_ra = '0; ba_wa = '0; ba_wd = addr_ff;
      sq_re = 1'b0; sq_we = 1'b0; sq_ra = '0; sq_wa = '0; sq_wd = '0;
      mt_re = 1'b0; mt_we = 1'b0; mt_ra = '0; mt_wa = '0; mt_wd = '0;
      vw_re = 1'b0; vw_we = 1'b0; vw_ra = '0; vw_wa = '0; vw_wd = '0;
      vb_re = 1'b0; vb_we = 1'b0; vb_ra = '0; vb_wa = '0; vb_wd = '0;
      st_re = 1'b0; st_we = 1'b0; st_ra = '0; st_wa = '0; sa_wd = '0; sb_wd = '0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            addr_in  = in_addr;
            v_in = '0;  i_in = '0;  j_in = '0;
         end
         S_SRCH: begin
            if (v_ff == vc_ff) begin
               ba_we = 1'b1;  ba_wa = vc_ff[VW-1:0];
               vc_in = vc_ff + CW'(1);
            end else begin
               ba_re = 1'b1;  ba_ra = v_ff[VW-1:0];
            end
         end
         S_CMP: begin
            if (ba_rd_ff != addr_ff) v_in = v_ff + CW'(1);
         end
         S_SEQ: begin
            sq_we = 1'b1;  sq_wa = bl_ff[VW-1:0];  sq_wd = v_ff[VW-1:0];
            bl_in = bl_inc;
         end
         S_CLR: begin
            mt_we = 1'b1;  mt_wa = {i_ff[VW-1:0], j_ff[VW-1:0]};
            vplaced_in = '0;  visited_in = '0;
            k_in = '0;  acc_in = '0;
            if (j_end) begin
               j_in = '0;
               i_in = i_end ? '0 : i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_PRD0: begin
            sq_re = 1'b1;  sq_ra = k_ff[VW-1:0];
         end
         S_PRD1: begin
            x_in  = sq_rd_ff;
            sq_re = 1'b1;  sq_ra = VW'(k_ff + CW'(1));
         end
         S_PRD2: begin
            y_in  = sq_rd_ff;
            mt_re = 1'b1;  mt_ra = {x_ff, sq_rd_ff};
         end
         S_PINC1: begin
            mt_we = 1'b1;  mt_wa = {x_ff, y_ff};  mt_wd = mt_rd_ff + AW'(1);
         end
         S_PRD3: begin
            mt_re = 1'b1;  mt_ra = {y_ff, x_ff};
         end
         S_PINC2: begin
            mt_we = 1'b1;  mt_wa = {y_ff, x_ff};  mt_wd = mt_rd_ff + AW'(1);
            k_in  = k_ff + CW'(1);
         end
         S_WRD: begin
            mt_re = 1'b1;  mt_ra = {i_ff[VW-1:0], j_ff[VW-1:0]};
         end
         S_WACC: begin
            acc_in = acc_ff + mt_rd_ff;
            if (j_end) begin
               vw_we = 1'b1;  vw_wa = i_ff[VW-1:0];  vw_wd = acc_ff + mt_rd_ff;
               j_in  = '0;
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_LBA: begin
            ba_re = 1'b1;  ba_ra = i_ff[VW-1:0];
         end
         S_LGET: begin
            vaddr_in = ba_rd_ff;
            p_in     = '0;
         end
         S_LRD: begin
            if (p_ff != total_ff) begin
               st_re = 1'b1;  st_ra = p_ff[PW-1:0];
            end else begin
               // next vertex, or on to the placement rounds
               j_in = '0;  acc_in = '0;  r_in = '0;  have_in = 1'b0;
               i_in = i_end ? '0 : i_ff + CW'(1);
            end
         end
         S_LCMP: begin
            if (sa_rd_ff == vaddr_ff) begin
               vplaced_in[i_ff[VW-1:0]] = 1'b1;
               vb_we = 1'b1;  vb_wa = i_ff[VW-1:0];  vb_wd = sb_rd_ff;
               j_in = '0;  acc_in = '0;  r_in = '0;  have_in = 1'b0;
               i_in = i_end ? '0 : i_ff + CW'(1);
            end else begin
               p_in = p_ff + TW'(1);
            end
         end
         S_SRD: begin
            vw_re = 1'b1;  vw_ra = i_ff[VW-1:0];
         end
         S_SCMP: begin
            if (!visited_ff[i_ff[VW-1:0]] && (!have_ff || (vw_rd_ff > bestw_ff))) begin
               x_in = i_ff[VW-1:0];  bestw_in = vw_rd_ff;  have_in = 1'b1;
            end
            i_in = i_end ? '0 : i_ff + CW'(1);
         end
         S_PICK: begin
            visited_in[x_ff] = 1'b1;
            j_in = '0;
            for (int n = 0; n < MAX_BANKS; n++) bw_in[n] = '0;
            if (vplaced_ff[x_ff]) begin
               r_in = r_ff + CW'(1);  i_in = '0;  have_in = 1'b0;
            end
         end
         S_BRD: begin
            mt_re = 1'b1;  mt_ra = {x_ff, j_ff[VW-1:0]};
            vb_re = 1'b1;  vb_ra = j_ff[VW-1:0];
         end
         S_BACC: begin
            if (vplaced_ff[j_ff[VW-1:0]] && ({1'b0, vb_rd_ff} < nb))
               bw_in[bw_sel] = bw_cur + mt_rd_ff;
            j_in = j_ff + CW'(1);
            b_in = '0;
         end
         S_BEST: begin
            if (b_ff == '0) begin
               best_in = '0;  bbw_in = bw_cur;  bld_in = load_cur;
            end else if ((bbw_ff > bw_cur) || ((bbw_ff == bw_cur) && (bld_ff > load_cur))) begin
               best_in = b_ff;  bbw_in = bw_cur;  bld_in = load_cur;
            end
            b_in = b_ff + BANK_W'(1);
         end
         S_BADDR: begin
            ba_re = 1'b1;  ba_ra = x_ff;
         end
         S_EMIT: begin
            out_valid = pend_v_ff;
            if (emit_go) begin
               pend_v_in    = 1'b1;
               pend_in.addr = ba_rd_ff;
               pend_in.bank = best_ff;
               pend_in.full = full;
               pend_in.last = 1'b0;
               if (!full) begin
                  st_we = 1'b1;  st_wa = total_ff[PW-1:0];
                  sa_wd = ba_rd_ff;  sb_wd = best_ff;
                  total_in = total_ff + TW'(1);
                  load_in[best_ff] = load_ff[best_ff] + TW'(1);
                  vplaced_in[x_ff] = 1'b1;
                  vb_we = 1'b1;  vb_wa = x_ff;  vb_wd = best_ff;
               end
               r_in = r_ff + CW'(1);  i_in = '0;  have_in = 1'b0;
            end
         end
         S_FIN: begin
            out_valid     = pend_v_ff;
            out_data.last = 1'b1;
            if (emit_go) begin
               pend_v_in = 1'b0;  vc_in = '0;  bl_in = '0;
            end
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vc_ff     <= '0;
         bl_ff     <= '0;
         total_ff  <= '0;
         pend_v_ff <= 1'b0;
         for (int n = 0; n < MAX_BANKS; n++) load_ff[n] <= '0;
      end else begin
         state_ff  <= state_in;
         vc_ff     <= vc_in;
         bl_ff     <= bl_in;
         total_ff  <= total_in;
         pend_v_ff <= pend_v_in;
         load_ff   <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;  i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;  r_ff <= r_in;
      x_ff <= x_in;  y_ff <= y_in;  acc_ff <= acc_in;  bestw_ff <= bestw_in;
      bbw_ff <= bbw_in;  have_ff <= have_in;  addr_ff <= addr_in;  vaddr_ff <= vaddr_in;
      p_ff <= p_in;  bld_ff <= bld_in;  vplaced_ff <= vplaced_in;  visited_ff <= visited_in;
      bw_ff <= bw_in;  b_ff <= b_in;  best_ff <= best_in;  pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (ba_we) ba_mem[ba_wa] <= ba_wd;
      if (ba_re) ba_rd_ff <= ba_mem[ba_ra];
      if (sq_we) sq_mem[sq_wa] <= sq_wd;
      if (sq_re) sq_rd_ff <= sq_mem[sq_ra];
      if (mt_we) mt_mem[mt_wa] <= mt_wd;
      if (mt_re) mt_rd_ff <= mt_mem[mt_ra];
      if (vw_we) vw_mem[vw_wa] <= vw_wd;
      if (vw_re) vw_rd_ff <= vw_mem[vw_ra];
      if (vb_we) vb_mem[vb_wa] <= vb_wd;
      if (vb_re) vb_rd_ff <= vb_mem[vb_ra];
      if (st_we) begin
         sa_mem[st_wa] <= sa_wd;
         sb_mem[st_wa] <= sb_wd;
      end
      if (st_re) begin
         sa_rd_ff <= sa_mem[st_ra];
         sb_rd_ff <= sb_mem[st_ra];
      end
   end

endmodule
